FILE: rtl/rsm_pkg.sv
package rsm_pkg;

    // Table geometry and field widths.
    localparam int PATTERNS      = 32;
    localparam int MAX_LEN       = 16;
    localparam int POSITION_BITS = 16;
    localparam int SLOT_W        = $clog2(PATTERNS);
    localparam int SYM_W         = $clog2(MAX_LEN);
    localparam int LEN_W         = $clog2(MAX_LEN + 1);
    localparam int CNT_W         = $clog2(PATTERNS + 1);
    localparam int BYTE_W        = 8;

    // Request types.
    localparam logic REQ_PATTERN  = 1'b0;
    localparam logic REQ_SEQUENCE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ACTIVE = 1'b0;
    localparam logic CFG_MINLEN = 1'b1;

    // One full pattern row, or one window of bytes; element 0 is the oldest.
    typedef logic [MAX_LEN-1:0][BYTE_W-1:0] t_row;

    // Write port of the pattern table.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] slot;
        logic [SYM_W-1:0]  pos;
        logic [BYTE_W-1:0] sym;
        logic [LEN_W-1:0]  len;
    } t_tbl_wr;

    // Controls of the sequence window.
    typedef struct packed {
        logic              shift;
        logic [BYTE_W-1:0] data;
        logic              load;
        logic              pop;
    } t_win_ctrl;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

endpackage

FILE: rtl/restriction_site_matcher_top.sv
// Pattern writes, and sequence bytes that report no position, leave the block idle and ready.
// One shared row comparator scans the active slots (at most 32) per start position: after
// PREP, SCAN reads the slots in order and stops at the first match, then EMIT gives the result.
// A byte that reports one position holds the input through the scan and any output
// stalls; a flush reports all pending positions, up to 16, one after the other.
// Synchronous active-low reset empties the window, clears pattern lengths to unused, sets
// active_patterns to 0 and min_length to 4, and leaves pattern symbols as they are.
module restriction_site_matcher_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [5:0]                         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_req_type,
    input  logic [4:0]                         i_pattern_slot,
    input  logic [3:0]                         i_symbol_pos,
    input  logic [4:0]                         i_pattern_len,
    input  logic [7:0]                         i_data_byte,
    input  logic                               i_is_last,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [rsm_pkg::POSITION_BITS-1:0]  o_position,
    output logic                               o_match_found,
    output logic [4:0]                         o_pattern_index,
    output logic                               o_last_result
);
    import rsm_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    t_state             r_state, n_state;
    logic [5:0]         r_active;
    logic [LEN_W-1:0]   r_min_len;
    logic               r_flush, n_flush;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_cmp_vld, n_cmp_vld;
    logic [SLOT_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic               r_match, n_match;
    logic [SLOT_W-1:0]  r_match_idx, n_match_idx;
    logic [POSITION_BITS-1:0] r_next_pos, n_next_pos;

    logic               r_out_vld, n_out_vld;
    logic [POSITION_BITS-1:0] r_out_pos, n_out_pos;
    logic               r_out_match, n_out_match;
    logic [SLOT_W-1:0]  r_out_idx, n_out_idx;
    logic               r_out_last, n_out_last;

    t_tbl_wr            tbl_wr;
    t_win_ctrl          win_ctrl;
    logic               rd_en;
    t_row               row;
    t_row               aligned;
    logic [LEN_W-1:0]   row_len;
    logic [LEN_W-1:0]   buffered;
    logic               hit;
    logic [CNT_W-1:0]   limit;
    logic               in_fire;
    logic               out_free;
    logic               issue;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_min_len <= LEN_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE: r_active  <= i_cfg_data;
                CFG_MINLEN: r_min_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign limit    = (r_active > 6'(PATTERNS)) ? CNT_W'(PATTERNS) : CNT_W'(r_active);
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_vld || i_out_ready;
    assign issue    = (r_state == ST_SCAN) && (r_idx < limit) && !(r_cmp_vld && hit);

    // Pattern table write port.
    always_comb begin
        tbl_wr.we   = in_fire && (i_req_type == REQ_PATTERN);
        tbl_wr.slot = i_pattern_slot;
        tbl_wr.pos  = i_symbol_pos;
        tbl_wr.sym  = i_data_byte;
        tbl_wr.len  = i_pattern_len;
    end

    assign rd_en = issue;

    rsm_pattern_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (tbl_wr),
        .i_rd_en   (rd_en),
        .i_rd_slot (r_idx[SLOT_W-1:0]),
        .o_row     (row),
        .o_len     (row_len)
    );

    // Window controls.
    always_comb begin
        win_ctrl.shift = in_fire && (i_req_type == REQ_SEQUENCE);
        win_ctrl.data  = i_data_byte;
        win_ctrl.load  = (r_state == ST_PREP);
        win_ctrl.pop   = (r_state == ST_EMIT) && out_free;
    end

    rsm_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (win_ctrl),
        .o_buffered (buffered),
        .o_aligned  (aligned)
    );

    rsm_compare_unit u_cmp (
        .i_row      (row),
        .i_window   (aligned),
        .i_len      (row_len),
        .i_buffered (buffered),
        .i_min_len  (r_min_len),
        .o_hit      (hit)
    );

    assign o_in_ready = (r_state == ST_IDLE);

    // Sequencer: one start position is checked against the slots in turn.
    always_comb begin
        n_state     = r_state;
        n_flush     = r_flush;
        n_idx       = r_idx;
        n_cmp_vld   = 1'b0;
        n_cmp_idx   = r_cmp_idx;
        n_match     = r_match;
        n_match_idx = r_match_idx;
        n_next_pos  = r_next_pos;
        n_out_vld   = r_out_vld && !i_out_ready;
        n_out_pos   = r_out_pos;
        n_out_match = r_out_match;
        n_out_idx   = r_out_idx;
        n_out_last  = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (in_fire && (i_req_type == REQ_SEQUENCE)) begin
                    n_flush = i_is_last;
                    if (i_is_last || (buffered == LEN_W'(MAX_LEN - 1))
                        || (buffered == LEN_W'(MAX_LEN))) begin
                        n_state = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                n_idx   = '0;
                n_match = 1'b0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (issue) begin
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[SLOT_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                end
                if (r_cmp_vld && hit) begin
                    n_match     = 1'b1;
                    n_match_idx = r_cmp_idx;
                    n_state     = ST_EMIT;
                end else if (!r_cmp_vld && (r_idx >= limit)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_vld   = 1'b1;
                    n_out_pos   = r_next_pos;
                    n_out_match = r_match;
                    n_out_idx   = r_match ? r_match_idx : '0;
                    n_out_last  = r_flush && (buffered == LEN_W'(1));
                    if (r_next_pos != POS_MAX) begin
                        n_next_pos = r_next_pos + POSITION_BITS'(1);
                    end
                    if (r_flush && (buffered > LEN_W'(1))) begin
                        n_state = ST_PREP;
                    end else begin
                        if (r_flush) begin
                            n_next_pos = '0;
                        end
                        n_flush = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_flush    <= 1'b0;
            r_cmp_vld  <= 1'b0;
            r_next_pos <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_flush    <= n_flush;
            r_cmp_vld  <= n_cmp_vld;
            r_next_pos <= n_next_pos;
            r_out_vld  <= n_out_vld;
        end
    end

    // Scan and output payload.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_match     <= n_match;
        r_match_idx <= n_match_idx;
        r_out_pos   <= n_out_pos;
        r_out_match <= n_out_match;
        r_out_idx   <= n_out_idx;
        r_out_last  <= n_out_last;
    end

    assign o_out_valid     = r_out_vld;
    assign o_position      = r_out_pos;
    assign o_match_found   = r_out_match;
    assign o_pattern_index = r_out_idx;
    assign o_last_result   = r_out_last;

endmodule

FILE: rtl/rsm_pattern_table.sv
module rsm_pattern_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rsm_pkg::t_tbl_wr           i_wr,
    input  logic                       i_rd_en,
    input  logic [rsm_pkg::SLOT_W-1:0] i_rd_slot,
    output rsm_pkg::t_row              o_row,
    output logic [rsm_pkg::LEN_W-1:0]  o_len
);
    import rsm_pkg::*;

    t_row             mem [PATTERNS];
    logic [LEN_W-1:0] r_len [PATTERNS];
    t_row             r_row;
    logic [LEN_W-1:0] r_len_q;
    logic [LEN_W-1:0] wr_len;

    // Lengths above the row size are stored as the row size.
    assign wr_len = (i_wr.len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : i_wr.len;

    // Symbol memory: one byte lane written, one whole row read.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.slot][i_wr.pos] <= i_wr.sym;
        end
        if (i_rd_en) begin
            r_row <= mem[i_rd_slot];
        end
    end

    // Pattern lengths clear to zero, which marks a slot unused.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PATTERNS; k++) begin
                r_len[k] <= '0;
            end
        end else if (i_wr.we) begin
            r_len[i_wr.slot] <= wr_len;
        end
    end

    // Length read is registered alongside the row.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_len_q <= r_len[i_rd_slot];
        end
    end

    assign o_row = r_row;
    assign o_len = r_len_q;

endmodule

FILE: rtl/rsm_window.sv
module rsm_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rsm_pkg::t_win_ctrl        i_ctrl,
    output logic [rsm_pkg::LEN_W-1:0] o_buffered,
    output rsm_pkg::t_row             o_aligned
);
    import rsm_pkg::*;

    t_row             r_recent;
    t_row             r_aligned;
    logic [LEN_W-1:0] r_buffered;
    logic [LEN_W-1:0] base;
    logic [SYM_W+2:0] shamt;

    // Newest byte enters at the top, the oldest falls out at element 0.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_recent <= {i_ctrl.data, r_recent[MAX_LEN-1:1]};
        end
    end

    // Count of bytes whose start position is not yet reported.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffered <= '0;
        end else if (i_ctrl.shift) begin
            if (r_buffered < LEN_W'(MAX_LEN)) begin
                r_buffered <= r_buffered + LEN_W'(1);
            end
        end else if (i_ctrl.pop) begin
            r_buffered <= r_buffered - LEN_W'(1);
        end
    end

    // Align the oldest pending byte to element 0 once per start position.
    assign base  = LEN_W'(MAX_LEN) - r_buffered;
    assign shamt = {base[SYM_W-1:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_aligned <= r_recent >> shamt;
        end
    end

    assign o_buffered = r_buffered;
    assign o_aligned  = r_aligned;

endmodule

FILE: rtl/rsm_compare_unit.sv
module rsm_compare_unit (
    input  rsm_pkg::t_row             i_row,
    input  rsm_pkg::t_row             i_window,
    input  logic [rsm_pkg::LEN_W-1:0] i_len,
    input  logic [rsm_pkg::LEN_W-1:0] i_buffered,
    input  logic [rsm_pkg::LEN_W-1:0] i_min_len,
    output logic                      o_hit
);
    import rsm_pkg::*;

    logic [MAX_LEN-1:0] lane_ok;
    logic               len_ok;

    // Every byte inside the pattern length has to agree.
    always_comb begin
        for (int i = 0; i < MAX_LEN; i++) begin
            lane_ok[i] = (LEN_W'(i) >= i_len) || (i_row[i] == i_window[i]);
        end
    end

    // Empty, too short, or running past the window never matches.
    assign len_ok = (i_len != '0) && (i_len >= i_min_len) && (i_len <= i_buffered);
    assign o_hit  = len_ok && (&lane_ok);

endmodule

FILE: test/restriction_site_checker.sv
module restriction_site_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [5:0]                        i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic                              i_req_type,
    input  logic [4:0]                        i_pattern_slot,
    input  logic [3:0]                        i_symbol_pos,
    input  logic [4:0]                        i_pattern_len,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_is_last,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [rsm_pkg::POSITION_BITS-1:0] i_position,
    input  logic                              i_match_found,
    input  logic [4:0]                        i_pattern_index,
    input  logic                              i_last_result,
    output int                                o_mismatches,
    output int                                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import rsm_pkg::*;

    // One reported start position.
    typedef struct packed {
        logic [POSITION_BITS-1:0] position;
        logic                     match_found;
        logic [4:0]               pattern_index;
        logic                     last_result;
    } t_site_result;

    // Shadow of the site table, the byte window and the registers.
    logic [7:0]               site_symbols [PATTERNS][MAX_LEN];
    logic [LEN_W-1:0]         site_lengths [PATTERNS];
    logic [7:0]               window_bytes [MAX_LEN];
    int unsigned              pending_starts;
    logic [POSITION_BITS-1:0] next_start;
    logic [5:0]               active_slots;
    logic [4:0]               min_site_len;
    t_site_result             expected_sites [$];
    int                       mismatches = 0;

    // Finds the lowest active site that matches at the oldest pending start,
    // then retires that start.
    function automatic t_site_result scan_start(input logic final_start);
        t_site_result res;
        int           limit;
        int           base;
        int           slen;
        bit           hit;
        res = '0;
        res.position = next_start;
        res.last_result = final_start;
        limit = (active_slots < PATTERNS) ? int'(active_slots) : PATTERNS;
        base = MAX_LEN - int'(pending_starts);
        for (int s = 0; s < limit; s++) begin
            slen = site_lengths[s];
            if (!res.match_found && slen != 0 && slen >= min_site_len &&
                slen <= int'(pending_starts)) begin
                hit = 1'b1;
                for (int k = 0; k < slen; k++)
                    if (window_bytes[base + k] != site_symbols[s][k]) hit = 1'b0;
                if (hit) begin
                    res.match_found = 1'b1;
                    res.pattern_index = 5'(s);
                end
            end
        end
        pending_starts--;
        if (next_start != '1) next_start++;
        return res;
    endfunction

    // Applies one accepted request transaction and queues the results it causes.
    task automatic accept_request();
        if (i_req_type == REQ_PATTERN) begin
            site_symbols[i_pattern_slot][i_symbol_pos] = i_data_byte;
            site_lengths[i_pattern_slot] =
                (i_pattern_len > MAX_LEN) ? LEN_W'(MAX_LEN) : i_pattern_len;
        end else begin
            for (int k = 0; k < MAX_LEN - 1; k++) window_bytes[k] = window_bytes[k + 1];
            window_bytes[MAX_LEN - 1] = i_data_byte;
            if (pending_starts < MAX_LEN) pending_starts++;
            if (!i_is_last) begin
                if (pending_starts == MAX_LEN)
                    expected_sites = {expected_sites, scan_start(1'b0)};
            end else begin
                // The last byte flushes every pending start and restarts the window.
                while (pending_starts > 0)
                    expected_sites = {expected_sites, scan_start(pending_starts == 1)};
                next_start = '0;
            end
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    // Compares one accepted result transaction with the oldest expectation.
    task automatic check_result();
        t_site_result want;
        if (expected_sites.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual position %0d",
                     $time, i_position);
        end else begin
            want = expected_sites.pop_front();
            compare_field("position", want.position, i_position);
            compare_field("match_found", want.match_found, i_match_found);
            compare_field("pattern_index", want.pattern_index, i_pattern_index);
            compare_field("last_result", want.last_result, i_last_result);
        end
    endtask

    // Register writes, then requests, then results, all seen at the clock edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (site_lengths[s]) site_lengths[s] = '0;
            pending_starts = 0;
            next_start = '0;
            active_slots = '0;
            min_site_len = 5'd4;
            expected_sites.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ACTIVE) active_slots = i_cfg_data;
                if (i_cfg_index == CFG_MINLEN) min_site_len = i_cfg_data[4:0];
            end
            if (i_in_valid && i_in_ready) accept_request();
            if (i_out_valid && i_out_ready) check_result();
        end
        o_mismatches = mismatches;
        o_outstanding = expected_sites.size();
    end

endmodule

FILE: test/tb_restriction_site_matcher_top.sv
module tb_restriction_site_matcher_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rsm_pkg::*;

    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 200;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SAT_BYTES     = (1 << POSITION_BITS) + 4;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam logic [7:0] BASES [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

    typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_MOSTLY} t_rx_pattern;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic                     cfg_index;
    logic [5:0]               cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     req_type;
    logic [4:0]               pattern_slot;
    logic [3:0]               symbol_pos;
    logic [4:0]               pattern_len;
    logic [7:0]               data_byte;
    logic                     is_last;
    logic                     out_valid;
    logic                     out_ready;
    logic [POSITION_BITS-1:0] position;
    logic                     match_found;
    logic [4:0]               pattern_index;
    logic                     last_result;
    int                       mismatches;
    int                       outstanding;

    // Copy of what was written, used only to build sequences that hit sites.
    logic [7:0] site_sym [PATTERNS][MAX_LEN];
    int         site_len [PATTERNS];
    int         cur_active = 0;
    int         burst_left = 0;
    int         items_sent = 0;
    int         cycle_count = 0;
    bit         eager = 1'b0;
    bit         rx_open = 1'b0;
    t_rx_pattern rx_pattern = RX_OPEN;
    int         rx_left = 0;
    int         rx_phase = 0;

    restriction_site_matcher_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_pattern_slot  (pattern_slot),
        .i_symbol_pos    (symbol_pos),
        .i_pattern_len   (pattern_len),
        .i_data_byte     (data_byte),
        .i_is_last       (is_last),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_position      (position),
        .o_match_found   (match_found),
        .o_pattern_index (pattern_index),
        .o_last_result   (last_result)
    );

    restriction_site_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_req_type      (req_type),
        .i_pattern_slot  (pattern_slot),
        .i_symbol_pos    (symbol_pos),
        .i_pattern_len   (pattern_len),
        .i_data_byte     (data_byte),
        .i_is_last       (is_last),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_position      (position),
        .i_match_found   (match_found),
        .i_pattern_index (pattern_index),
        .i_last_result   (last_result),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: picks a new stall pattern at random whenever the current one runs out.
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_pattern = t_rx_pattern'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        rx_phase++;
        if (rx_open || rx_pattern == RX_OPEN) out_ready <= 1'b1;
        else if (rx_pattern == RX_COIN) out_ready <= 1'($urandom_range(0, 1));
        else if (rx_pattern == RX_PERIODIC) out_ready <= (rx_phase % 5 < 2);
        else out_ready <= ($urandom_range(0, 3) != 0);
    end

    // Hard stop if the run hangs.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_restriction_site_matcher_top failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_symbol();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : BASES[$urandom_range(0, 3)];
    endfunction

    // Mostly site-like lengths, with empty, short, full and oversized ones mixed in.
    function automatic int pick_length();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(1, 3);
            2: return MAX_LEN;
            3: return $urandom_range(MAX_LEN + 1, 31);
            default: return $urandom_range(4, 8);
        endcase
    endfunction

    // Presents one request transaction and returns at the edge that accepts it.
    // Valid is left high; the next call or an idle phase decides what follows.
    task automatic send_request(input logic rtype, input logic [4:0] s, input logic [3:0] p,
                                input logic [4:0] l, input logic [7:0] b, input logic lst);
        int gap;
        if (!eager && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        in_valid     <= 1'b1;
        req_type     <= rtype;
        pattern_slot <= s;
        symbol_pos   <= p;
        pattern_len  <= l;
        data_byte    <= b;
        is_last      <= lst;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (rtype == REQ_PATTERN) begin
            site_sym[s][p] = b;
            site_len[s] = (l > MAX_LEN) ? MAX_LEN : int'(l);
        end
    endtask

    task automatic write_symbol(input int s, input int p, input int l, input logic [7:0] b);
        send_request(REQ_PATTERN, 5'(s), 4'(p), 5'(l), b, 1'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst);
        send_request(REQ_SEQUENCE, 5'($urandom), 4'($urandom), 5'($urandom), b, lst);
    endtask

    // Rewrites a whole site; an empty one still takes one symbol write.
    task automatic load_site(input int s, input int l);
        int n;
        n = (l > MAX_LEN) ? MAX_LEN : l;
        if (n == 0) write_symbol(s, $urandom_range(0, MAX_LEN - 1), 0, pick_symbol());
        for (int p = 0; p < n; p++) write_symbol(s, p, l, pick_symbol());
    endtask

    // Stops sending, waits for every expected result and for the block to go idle.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 6'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reconfigure(input int active, input int min_len);
        settle();
        write_config(CFG_ACTIVE, active);
        write_config(CFG_MINLEN, min_len);
        cur_active = active;
    endtask

    // Sends a window of bytes; most carry copies of active sites so that
    // matches are common. A site symbol is rewritten now and then mid-window.
    task automatic run_window(input int n, input bit noise, input bit close);
        logic [7:0] seq_bytes [$];
        int         s;
        int         limit;
        limit = (cur_active > PATTERNS) ? PATTERNS : cur_active;
        while (seq_bytes.size() < n) begin
            if (!noise && limit > 0 && $urandom_range(0, 2) == 0) begin
                s = $urandom_range(0, limit - 1);
                for (int k = 0; k < site_len[s]; k++) seq_bytes = {seq_bytes, site_sym[s][k]};
            end else begin
                seq_bytes = {seq_bytes, (noise ? 8'($urandom) : pick_symbol())};
            end
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 29) == 0) begin
                s = $urandom_range(0, PATTERNS - 1);
                write_symbol(s, $urandom_range(0, MAX_LEN - 1), site_len[s], pick_symbol());
            end
            send_byte(seq_bytes[k], close && k == n - 1);
        end
    endtask

    initial begin
        int start;
        int active;
        int min_len;
        int n;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ACTIVE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_type     = REQ_PATTERN;
        pattern_slot = '0;
        symbol_pos   = '0;
        pattern_len  = '0;
        data_byte    = '0;
        is_last      = 1'b0;
        out_ready    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Fill every symbol of the table so that no comparison reads an unwritten one.
        for (int s = 0; s < PATTERNS; s++) begin
            n = pick_length();
            for (int p = 0; p < MAX_LEN; p++) write_symbol(s, p, n, pick_symbol());
        end

        // Too many active slots, zero minimum: the empty site must still never match.
        // The flag on a symbol write is ignored, and an oversized length is clipped.
        reconfigure(63, 0);
        send_request(REQ_PATTERN, 5'd0, 4'd0, 5'd0, BASES[0], 1'b1);
        write_symbol(1, 0, 1, BASES[0]);
        send_request(REQ_PATTERN, 5'd31, 4'd15, 5'd31, 8'hFF, 1'b0);
        send_byte(BASES[0], 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // Only full-length sites qualify; the last slot is sent in full.
        reconfigure(63, MAX_LEN);
        for (int p = 0; p < MAX_LEN; p++) send_byte(site_sym[31][p], 1'b0);
        send_byte(BASES[0], 1'b1);

        // Random windows under changing settings.
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: active = 0;
                1: active = PATTERNS;
                2: active = 63;
                3: active = $urandom_range(PATTERNS + 1, 62);
                default: active = $urandom_range(1, PATTERNS);
            endcase
            case ($urandom_range(0, 9))
                0: min_len = 0;
                1: min_len = 1;
                2: min_len = MAX_LEN;
                3: min_len = $urandom_range(MAX_LEN + 1, 31);
                default: min_len = $urandom_range(2, 8);
            endcase
            reconfigure(active, min_len);
            repeat ($urandom_range(0, 2))
                load_site($urandom_range(0, PATTERNS - 1), pick_length());
            case ($urandom_range(0, 9))
                0: n = $urandom_range(1, 4);
                1: n = $urandom_range(30, 60);
                default: n = $urandom_range(5, 25);
            endcase
            run_window(n, $urandom_range(0, 7) == 0, $urandom_range(0, 6) != 0);
        end

        // One long window at full speed so that the position saturates.
        reconfigure(1, 1);
        load_site(0, 2);
        eager = 1'b1;
        rx_open = 1'b1;
        for (int k = 0; k < SAT_BYTES; k++)
            send_byte(BASES[$urandom_range(0, 3)], k == SAT_BYTES - 1);
        eager = 1'b0;
        rx_open = 1'b0;

        // Drain and give the verdict.
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_restriction_site_matcher_top passed");
        else
            $display("tb_restriction_site_matcher_top failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rsm_pkg.sv
rtl/rsm_pattern_table.sv
rtl/rsm_window.sv
rtl/rsm_compare_unit.sv
rtl/restriction_site_matcher_top.sv
test/restriction_site_checker.sv
test/tb_restriction_site_matcher_top.sv
